FILE: hw/rtl/soft_power_button_latch_macros.svh
// assertion macros shared by the soft power button latch checkers
`ifndef SOFT_POWER_BUTTON_LATCH_MACROS_SVH
`define SOFT_POWER_BUTTON_LATCH_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SPBL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spbl same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SPBL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spbl next-cycle check failed");

`endif

FILE: hw/rtl/spbl_pkg.sv
// shared types and constants of the soft power button latch
package spbl_pkg;

	localparam int unsigned CNT_W     = 16;
	localparam int unsigned PHASE_W   = 4;
	localparam int unsigned CFG_IDX_W = 4;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PHASE_W-1:0]   phase_code_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// configuration register indexes
	localparam cfg_idx_t REG_STARTUP_DELAY = cfg_idx_t'(0);
	localparam cfg_idx_t REG_DEBOUNCE      = cfg_idx_t'(1);
	localparam cfg_idx_t REG_POLL_INTERVAL = cfg_idx_t'(2);
	localparam cfg_idx_t REG_HOLD_POLLS    = cfg_idx_t'(3);

	// register reset values
	localparam cnt_t RST_STARTUP_DELAY = cnt_t'(500);
	localparam cnt_t RST_DEBOUNCE      = cnt_t'(30);
	localparam cnt_t RST_POLL_INTERVAL = cnt_t'(20);
	localparam cnt_t RST_HOLD_POLLS    = cnt_t'(75);

	// highest phase code the sequencer ever reports
	localparam phase_code_t PHASE_LAST = phase_code_t'(8);

endpackage

FILE: hw/rtl/soft_power_button_latch.sv
// soft power switch with long-press turn-off, one millisecond tick per transaction
//
// input channel: in_valid/in_ready carry one button_pressed sample per tick.
// output channel: out_valid/out_ready carry supply_enable_n and sequencer_phase,
// showing the state right after the tick was applied; one result per tick.
// config channel: cfg_valid/cfg_ready write cfg_data into register cfg_index
// (0 start-up delay, 1 debounce, 2 poll interval, 3 hold poll count);
// cfg_ready is always high, unknown indexes are dropped.
// result: the result of a tick is registered and offered in the cycle after it is accepted.
// throughput: one tick per cycle while out_ready is high; the state update is a single
// 16-bit decrement and compare between the state registers and the result register.
// reset: supply off, phase 0 with the start-up delay loaded, registers at
// their defaults (500, 30, 20, 75), no result pending.
// stall: while a result waits, a new tick is still accepted if out_ready is
// high in the same cycle; otherwise in_ready drops until the result is taken.
module soft_power_button_latch
	import spbl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        button_pressed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        supply_enable_n,
	output phase_code_t sequencer_phase,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_idx_t    cfg_index,
	input  cnt_t        cfg_data
);

	typedef enum logic [PHASE_W-1:0] {
		PH_START     = 4'd0,
		PH_OFF_IDLE  = 4'd1,
		PH_ON_DEB    = 4'd2,
		PH_WAIT_REL  = 4'd3,
		PH_REL_DEB   = 4'd4,
		PH_ON_IDLE   = 4'd5,
		PH_HOLD_DEB  = 4'd6,
		PH_POLL      = 4'd7,
		PH_POLL_WAIT = 4'd8
	} phase_t;

	// configuration registers
	cnt_t startup_delay_q;
	cnt_t debounce_q;
	cnt_t poll_interval_q;
	cnt_t hold_polls_q;

	// sequencer state
	phase_t phase_q;
	cnt_t   delay_q;
	cnt_t   polls_q;
	logic   supply_on_q;

	// result register
	logic        out_valid_q;
	logic        supply_enable_n_q;
	phase_code_t seq_phase_q;

	phase_t phase_d;
	cnt_t   delay_d;
	cnt_t   polls_d;
	logic   supply_on_d;
	logic   delay_over;
	cnt_t   delay_dec;
	logic   in_take;
	logic   cfg_take;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid;

	assign out_valid       = out_valid_q;
	assign supply_enable_n = supply_enable_n_q;
	assign sequencer_phase = seq_phase_q;

	// running delay ends when the counter is at one or zero
	assign delay_over = (delay_q <= cnt_t'(1));
	assign delay_dec  = delay_over ? '0 : delay_q - cnt_t'(1);

	// next state for one tick
	always_comb begin
		phase_d     = phase_q;
		delay_d     = delay_q;
		polls_d     = polls_q;
		supply_on_d = supply_on_q;
		unique case (phase_q)
			PH_START: begin
				delay_d = delay_dec;
				if (delay_over) phase_d = PH_OFF_IDLE;
			end
			PH_OFF_IDLE: begin
				if (button_pressed) begin
					delay_d = debounce_q;
					phase_d = PH_ON_DEB;
				end
			end
			PH_ON_DEB: begin
				delay_d = delay_dec;
				if (delay_over) begin
					supply_on_d = 1'b1;
					phase_d     = PH_WAIT_REL;
				end
			end
			PH_WAIT_REL: begin
				if (!button_pressed) begin
					delay_d = debounce_q;
					phase_d = PH_REL_DEB;
				end
			end
			PH_REL_DEB: begin
				delay_d = delay_dec;
				if (delay_over) phase_d = supply_on_q ? PH_ON_IDLE : PH_OFF_IDLE;
			end
			PH_ON_IDLE: begin
				if (button_pressed) begin
					delay_d = debounce_q;
					phase_d = PH_HOLD_DEB;
				end
			end
			PH_HOLD_DEB: begin
				delay_d = delay_dec;
				if (delay_over) begin
					polls_d = hold_polls_q;
					phase_d = PH_POLL;
				end
			end
			PH_POLL: begin
				if (polls_q == '0) begin
					supply_on_d = 1'b0;
					phase_d     = PH_WAIT_REL;
				end else if (button_pressed) begin
					polls_d = polls_q - cnt_t'(1);
					delay_d = poll_interval_q;
					phase_d = PH_POLL_WAIT;
				end else begin
					delay_d = debounce_q;
					phase_d = PH_REL_DEB;
				end
			end
			PH_POLL_WAIT: begin
				delay_d = delay_dec;
				if (delay_over) phase_d = PH_POLL;
			end
			default: begin
				phase_d     = PH_START;
				supply_on_d = 1'b0;
				delay_d     = startup_delay_q;
			end
		endcase
	end

	// state, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			startup_delay_q   <= RST_STARTUP_DELAY;
			debounce_q        <= RST_DEBOUNCE;
			poll_interval_q   <= RST_POLL_INTERVAL;
			hold_polls_q      <= RST_HOLD_POLLS;
			phase_q           <= PH_START;
			delay_q           <= RST_STARTUP_DELAY;
			polls_q           <= '0;
			supply_on_q       <= 1'b0;
			out_valid_q       <= 1'b0;
			supply_enable_n_q <= 1'b1;
			seq_phase_q       <= phase_code_t'(PH_START);
		end else begin
			// tick transaction
			if (in_take) begin
				phase_q           <= phase_d;
				delay_q           <= delay_d;
				polls_q           <= polls_d;
				supply_on_q       <= supply_on_d;
				supply_enable_n_q <= !supply_on_d;
				seq_phase_q       <= phase_code_t'(phase_d);
			end
			if (in_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// register write transaction
			if (cfg_take) begin
				unique case (cfg_index)
					REG_STARTUP_DELAY: begin
						startup_delay_q <= cfg_data;
						if (phase_q == PH_START) delay_q <= cfg_data;
					end
					REG_DEBOUNCE:      debounce_q      <= cfg_data;
					REG_POLL_INTERVAL: poll_interval_q <= cfg_data;
					REG_HOLD_POLLS:    hold_polls_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: hw/rtl/spbl_checker.sv
// port-level checker for the soft power button latch, bound to the top level
`include "soft_power_button_latch_macros.svh"

module spbl_checker
	import spbl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        supply_enable_n,
	input phase_code_t sequencer_phase
);

	// every accepted tick yields a result in the next cycle
	`SPBL_ASSERT_NXT(a_result_follows, clk, arst_n, in_valid && in_ready, out_valid)

	// with no result pending the block always takes a tick
	`SPBL_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// a stalled result holds its payload
	`SPBL_ASSERT_NXT(a_stall_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(supply_enable_n) && $stable(sequencer_phase))

	// reported phase stays within the sequencer's range
	`SPBL_ASSERT_IMP(a_phase_range, clk, arst_n, out_valid, sequencer_phase <= PHASE_LAST)

endmodule

bind soft_power_button_latch spbl_checker u_spbl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.supply_enable_n (supply_enable_n),
	.sequencer_phase (sequencer_phase)
);

FILE: tb/tb_top.sv
// self-checking testbench for the soft power button latch
`timescale 1ns / 1ps

module tb_top;
	import spbl_pkg::*;

	// phase codes as reported on sequencer_phase
	localparam phase_code_t PH_STARTUP          = phase_code_t'(0);
	localparam phase_code_t PH_OFF_IDLE         = phase_code_t'(1);
	localparam phase_code_t PH_ON_DEBOUNCE      = phase_code_t'(2);
	localparam phase_code_t PH_WAIT_RELEASE     = phase_code_t'(3);
	localparam phase_code_t PH_RELEASE_DEBOUNCE = phase_code_t'(4);
	localparam phase_code_t PH_ON_IDLE          = phase_code_t'(5);
	localparam phase_code_t PH_HOLD_DEBOUNCE    = phase_code_t'(6);
	localparam phase_code_t PH_POLL             = phase_code_t'(7);
	localparam phase_code_t PH_POLL_WAIT        = phase_code_t'(8);

	// register indexes that decode to nothing
	localparam cfg_idx_t REG_UNUSED_FIRST = REG_HOLD_POLLS + cfg_idx_t'(1);
	localparam cfg_idx_t REG_UNUSED_LAST  = '1;

	localparam cnt_t CNT_MAX           = '1;
	localparam int   TIMING_SETS       = 8;
	localparam int   TICKS_PER_SET     = 195;
	localparam int   SHOWN_MISMATCHES  = 10;
	localparam int   LONGEST_RUN       = 400;

	typedef struct packed {
		logic        supply_enable_n;
		phase_code_t phase;
	} supply_status_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic        button_pressed = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic        supply_enable_n;
	phase_code_t sequencer_phase;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index      = REG_STARTUP_DELAY;
	cnt_t        cfg_data       = '0;

	// timing registers and sequencer state as the testbench sees them
	cnt_t        m_startup_delay = RST_STARTUP_DELAY;
	cnt_t        m_debounce      = RST_DEBOUNCE;
	cnt_t        m_poll_interval = RST_POLL_INTERVAL;
	cnt_t        m_hold_polls    = RST_HOLD_POLLS;
	phase_code_t m_phase         = PH_STARTUP;
	cnt_t        m_delay         = RST_STARTUP_DELAY;
	cnt_t        m_polls_left    = '0;
	logic        m_supply_on     = 1'b0;

	logic           pending_ticks[$];
	supply_status_t expected_status[$];
	supply_status_t next_status;

	bit allow_idle       = 1'b0;
	int gap_left         = 0;
	int stall_left       = 0;
	int ticks_sent       = 0;
	int results_checked  = 0;
	int mismatch_count   = 0;
	int unexpected_count = 0;
	int timing_sets      = 0;

	soft_power_button_latch u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.button_pressed  (button_pressed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.supply_enable_n (supply_enable_n),
		.sequencer_phase (sequencer_phase),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// one tick of a running delay; true on the tick that ends it
	function automatic bit delay_expired();
		if (m_delay > cnt_t'(1)) begin
			m_delay = m_delay - cnt_t'(1);
			return 1'b0;
		end
		m_delay = '0;
		return 1'b1;
	endfunction

	// apply one button tick to the sequencer and queue the status it shows
	function automatic void advance_sequencer(input logic pressed);
		case (m_phase)
			PH_STARTUP: begin
				if (delay_expired())
					m_phase = PH_OFF_IDLE;
			end
			PH_OFF_IDLE: begin
				if (pressed) begin
					m_delay = m_debounce;
					m_phase = PH_ON_DEBOUNCE;
				end
			end
			PH_ON_DEBOUNCE: begin
				if (delay_expired()) begin
					m_supply_on = 1'b1;
					m_phase     = PH_WAIT_RELEASE;
				end
			end
			PH_WAIT_RELEASE: begin
				if (!pressed) begin
					m_delay = m_debounce;
					m_phase = PH_RELEASE_DEBOUNCE;
				end
			end
			PH_RELEASE_DEBOUNCE: begin
				if (delay_expired())
					m_phase = m_supply_on ? PH_ON_IDLE : PH_OFF_IDLE;
			end
			PH_ON_IDLE: begin
				if (pressed) begin
					m_delay = m_debounce;
					m_phase = PH_HOLD_DEBOUNCE;
				end
			end
			PH_HOLD_DEBOUNCE: begin
				if (delay_expired()) begin
					m_polls_left = m_hold_polls;
					m_phase      = PH_POLL;
				end
			end
			PH_POLL: begin
				if (m_polls_left == '0) begin
					// held long enough: switch off and wait for release
					m_supply_on = 1'b0;
					m_phase     = PH_WAIT_RELEASE;
				end else if (pressed) begin
					m_polls_left = m_polls_left - cnt_t'(1);
					m_delay      = m_poll_interval;
					m_phase      = PH_POLL_WAIT;
				end else begin
					// released early, supply stays on
					m_delay = m_debounce;
					m_phase = PH_RELEASE_DEBOUNCE;
				end
			end
			PH_POLL_WAIT: begin
				if (delay_expired())
					m_phase = PH_POLL;
			end
			default: begin
				m_phase     = PH_STARTUP;
				m_supply_on = 1'b0;
				m_delay     = m_startup_delay;
			end
		endcase
		expected_status.push_back(supply_status_t'{supply_enable_n: !m_supply_on,
			phase: m_phase});
	endfunction

	// button tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid       <= 1'b0;
			button_pressed <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_sequencer(button_pressed);
				ticks_sent++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (allow_idle && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					in_valid       <= 1'b1;
					button_pressed <= pending_ticks.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// status monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					unexpected_count++;
					if (mismatch_count + unexpected_count <= SHOWN_MISMATCHES)
						$display("status transaction with none expected: supply_enable_n %0b phase %0d",
							supply_enable_n, sequencer_phase);
				end else begin
					next_status = expected_status.pop_front();
					results_checked++;
					if (supply_enable_n !== next_status.supply_enable_n ||
							sequencer_phase !== next_status.phase) begin
						mismatch_count++;
						if (mismatch_count + unexpected_count <= SHOWN_MISMATCHES)
							$display("status %0d: supply_enable_n exp %0b got %0b, phase exp %0d got %0d",
								results_checked, next_status.supply_enable_n, supply_enable_n,
								next_status.phase, sequencer_phase);
					end
				end
			end
			// receiver stall bursts
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// one register write transaction; the caller lowers cfg_valid after a group
	task automatic write_register(input cfg_idx_t idx, input cnt_t value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_STARTUP_DELAY: begin
				// during start-up the count restarts from the new value
				m_startup_delay = value;
				if (m_phase == PH_STARTUP)
					m_delay = value;
			end
			REG_DEBOUNCE: begin
				m_debounce = value;
			end
			REG_POLL_INTERVAL: begin
				m_poll_interval = value;
			end
			REG_HOLD_POLLS: begin
				m_hold_polls = value;
			end
			default: begin
			end
		endcase
	endtask

	task automatic program_timing(input cnt_t startup, input cnt_t debounce, input cnt_t poll,
			input cnt_t hold);
		write_register(REG_STARTUP_DELAY, startup);
		write_register(REG_DEBOUNCE, debounce);
		write_register(REG_POLL_INTERVAL, poll);
		write_register(REG_HOLD_POLLS, hold);
		timing_sets++;
	endtask

	// hold the sender until every status has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_ticks.size() != 0 || in_valid || expected_status.size() != 0);
		@(posedge clk);
	endtask

	// button levels pushed oldest bit first
	task automatic queue_pattern(input logic [31:0] levels, input int count);
		for (int i = count - 1; i >= 0; i--)
			pending_ticks.push_back(levels[i]);
	endtask

	// alternating press and release runs: most of random length up to a debounce
	// and a full long press, capped at LONGEST_RUN, some short glitches
	task automatic queue_button_runs(input int count);
		longint window;
		int     run;
		logic   level;
		window = longint'(m_debounce) + (longint'(m_poll_interval) + 1) *
			(longint'(m_hold_polls) + 1) + 4;
		if (window > LONGEST_RUN)
			window = LONGEST_RUN;
		level = 1'($urandom_range(0, 1));
		while (count > 0) begin
			if ($urandom_range(0, 3) == 0)
				run = $urandom_range(1, 3);
			else
				run = $urandom_range(1, int'(window));
			if (run > count)
				run = count;
			repeat (run) pending_ticks.push_back(level);
			count -= run;
			level = !level;
		end
	endtask

	// stimulus
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// longest start-up delay written during start-up, then unused indexes
		program_timing(CNT_MAX, RST_DEBOUNCE, RST_POLL_INTERVAL, RST_HOLD_POLLS);
		write_register(REG_UNUSED_FIRST, cnt_t'(1));
		write_register(REG_UNUSED_LAST, '0);
		cfg_valid <= 1'b0;
		queue_button_runs(TICKS_PER_SET);
		wait_drained();

		// zero delays and zero hold count: first poll switches off
		allow_idle = 1'b1;
		program_timing('0, '0, '0, '0);
		cfg_valid <= 1'b0;
		queue_pattern(32'b110011101, 9);
		wait_drained();

		// short debounce and poll interval, two polls: a press that switches on, then a full hold
		program_timing(RST_STARTUP_DELAY, cnt_t'(1), cnt_t'(1), cnt_t'(2));
		cfg_valid <= 1'b0;
		queue_pattern(32'b1001101001111111100, 19);

		// random timing sets, the last at the top of every range with no idling
		for (int k = 0; k < TIMING_SETS; k++) begin
			wait_drained();
			if (k == TIMING_SETS - 1) begin
				allow_idle = 1'b0;
				program_timing(CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX);
			end else begin
				allow_idle = ($urandom_range(0, 3) != 0);
				program_timing(cnt_t'($urandom),
					cnt_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) :
						$urandom_range(0, 6)),
					cnt_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) :
						$urandom_range(0, 4)),
					cnt_t'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) :
						$urandom_range(0, 5)));
			end
			cfg_valid <= 1'b0;
			queue_button_runs(TICKS_PER_SET);
		end

		wait_drained();
		repeat (4) @(posedge clk);

		$display("%0d button ticks under %0d timing settings, %0d status results compared",
			ticks_sent, timing_sets, results_checked);
		$display("%0d mismatching results, %0d unexpected results, %0d still outstanding",
			mismatch_count, unexpected_count, expected_status.size());
		if (mismatch_count == 0 && unexpected_count == 0 && expected_status.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("timed out with %0d ticks queued and %0d results outstanding",
			pending_ticks.size(), expected_status.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: soft_power_button_latch.f
+incdir+hw/rtl
hw/rtl/spbl_pkg.sv
hw/rtl/soft_power_button_latch.sv
hw/rtl/spbl_checker.sv
tb/tb_top.sv
